/* design/stq_pkg.sv */
// Shared types and codes for the sorted timer queue.
`default_nettype none

package stq_pkg;

    // Field widths
    localparam int FUNC_W    = 2;
    localparam int DELAY_W   = 16;
    localparam int TAG_W     = 32;
    localparam int HANDLE_W  = 4;
    localparam int STATUS_W  = 3;
    localparam int TIMEOUT_W = 32;
    localparam int TPS_W     = 20;

    // Ticks per second after reset
    localparam logic [TPS_W-1:0] TPS_RESET = 20'd1000;

    // Most results one tick may emit
    localparam int MAX_RESULTS = 16;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_IDLE_TICK = 3'd5;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [DELAY_W-1:0]  delay_seconds;
        logic [TAG_W-1:0]    callback_tag;
        logic [HANDLE_W-1:0] entry_handle;
    } stq_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [HANDLE_W-1:0]  handle_out;
        logic [TAG_W-1:0]     tag_out;
        logic [TIMEOUT_W-1:0] next_timeout;
        logic                 queue_empty;
        logic                 last;
    } stq_out_t;

endpackage

`default_nettype wire

/* design/sorted_timer_queue_unit.sv */
// Sorted timer queue: top level with the entry store and its walk sequencer.
//
// Usage: requests arrive on in_valid/in_ready/in_data (tick, add, remove,
// update); results leave on out_valid/out_ready/out_data. A tick may give
// several results in a row, the final one with last set; every other
// request gives exactly one result. ticks_per_second is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the block is
// idle, which the block itself does not enforce. The block takes one
// request at a time; in_ready is low while it works. An add scans for
// the lowest free handle, then walks the store to insert; remove and
// update first walk it to find the entry; a tick pops due entries one by
// one. The store has a single read port and is walked one entry a cycle
// to shift, search and place entries.
// Reset empties the queue, clears the clock and all handles and loads
// ticks_per_second with 1000; the store itself needs no clearing pass.
// Results sit in an output register; while the receiver stalls, the
// sequencer holds its next result and waits.
`default_nettype none

module sorted_timer_queue_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_WIDTH  = 48
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire stq_pkg::stq_in_t            in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output stq_pkg::stq_out_t                out_data,
    input  wire logic                        cfg_wr_en,
    input  wire logic [stq_pkg::TPS_W-1:0]   cfg_wr_data
);

    localparam int AW     = $clog2(QUEUE_DEPTH);
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int HCW    = (AW > stq_pkg::HANDLE_W) ? AW : stq_pkg::HANDLE_W;
    localparam int PROD_W = stq_pkg::DELAY_W + stq_pkg::TPS_W;
    localparam int SW     = ((TIME_WIDTH > PROD_W) ? TIME_WIDTH : PROD_W) + 1;
    localparam int NW     = $clog2(stq_pkg::MAX_RESULTS + 1);
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

    typedef struct packed {
        logic [TIME_WIDTH-1:0]       expiry;
        logic [stq_pkg::TAG_W-1:0]   tag;
        logic [AW-1:0]               handle;
    } entry_t;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_DECODE   = 10'b00_0000_0010,
        S_FREE     = 10'b00_0000_0100,
        S_FIND_RD  = 10'b00_0000_1000,
        S_FIND     = 10'b00_0001_0000,
        S_INS_RD   = 10'b00_0010_0000,
        S_INS      = 10'b00_0100_0000,
        S_INS_LAST = 10'b00_1000_0000,
        S_TICK_CHK = 10'b01_0000_0000,
        S_EMIT     = 10'b10_0000_0000
    } state_t;

    // Handle of the entry store widened or cut to the result field
    function automatic logic [stq_pkg::HANDLE_W-1:0] to_hout(input logic [AW-1:0] h);
        logic [HCW-1:0] w;
        w = HCW'(h);
        return w[stq_pkg::HANDLE_W-1:0];
    endfunction

    // Control registers
    state_t                          state_reg, state_next;
    logic [stq_pkg::TPS_W-1:0]       tps_reg, tps_next;
    logic [TIME_WIDTH-1:0]           clock_reg, clock_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic [QUEUE_DEPTH-1:0]          in_use_reg, in_use_next;
    logic [NW-1:0]                   n_reg, n_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            found_reg, found_next;

    // Payload registers
    stq_pkg::stq_in_t                req_reg, req_next;
    logic [PROD_W-1:0]               prod_reg, prod_next;
    logic [TIME_WIDTH-1:0]           exp_new_reg, exp_new_next;
    entry_t                          head_reg, head_next;
    logic [CW-1:0]                   pos_reg, pos_next;
    logic [AW-1:0]                   target_reg, target_next;
    logic [AW-1:0]                   free_reg, free_next;
    logic [stq_pkg::TAG_W-1:0]       kept_tag_reg, kept_tag_next;
    logic [stq_pkg::STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [stq_pkg::HANDLE_W-1:0]    res_handle_reg, res_handle_next;
    logic [stq_pkg::TAG_W-1:0]       res_tag_reg, res_tag_next;
    stq_pkg::stq_out_t               out_data_reg, out_data_next;

    // Entry store
    entry_t                          entry_mem [QUEUE_DEPTH];
    entry_t                          rdata_reg;
    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr;
    logic [AW-1:0]                   mem_raddr;
    entry_t                          mem_wdata;

    // Datapath helpers
    logic [HCW-1:0]                  h_ext;
    logic                            h_ok;
    logic [SW-1:0]                   sum_wide;
    logic [TIME_WIDTH-1:0]           add_sat;
    logic [TIME_WIDTH:0]             diff;
    logic [stq_pkg::TIMEOUT_W-1:0]   nt;
    logic                            head_due;
    logic                            emit_last;
    logic [CW-1:0]                   pos_inc;
    logic [CW-1:0]                   pos_dec;
    logic [CW-1:0]                   pos_m2;
    logic [CW-1:0]                   cnt_dec;
    entry_t                          new_entry;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Handle check for remove and update
    assign h_ext = HCW'(req_reg.entry_handle);
    assign h_ok  = ({1'b0, h_ext} < (HCW + 1)'(QUEUE_DEPTH)) && in_use_reg[h_ext[AW-1:0]];

    // Saturating expiry = clock + delay ticks
    assign sum_wide = SW'(clock_reg) + SW'(prod_reg);
    assign add_sat  = ((sum_wide >> TIME_WIDTH) != '0) ? TIME_MAX : sum_wide[TIME_WIDTH-1:0];

    // Ticks until the head entry expires
    assign head_due = (cnt_reg != '0) && (head_reg.expiry <= clock_reg);
    assign diff     = {1'b0, head_reg.expiry} - {1'b0, clock_reg};
    always_comb
    begin
        if (cnt_reg == '0)
            nt = '1;
        else if (head_reg.expiry <= clock_reg)
            nt = '0;
        else if ((diff >> stq_pkg::TIMEOUT_W) != '0)
            nt = '1;
        else
            nt = diff[stq_pkg::TIMEOUT_W-1:0];
    end

    assign emit_last = (res_status_reg != stq_pkg::ST_EXPIRED) ||
                       !(head_due && (n_reg < NW'(stq_pkg::MAX_RESULTS)));

    assign pos_inc   = pos_reg + 1'b1;
    assign pos_dec   = pos_reg - 1'b1;
    assign pos_m2    = pos_reg - CW'(2);
    assign cnt_dec   = cnt_reg - 1'b1;
    assign new_entry = '{expiry: exp_new_reg, tag: kept_tag_reg, handle: target_reg};

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        tps_next        = cfg_wr_en ? cfg_wr_data : tps_reg;
        clock_next      = clock_reg;
        cnt_next        = cnt_reg;
        in_use_next     = in_use_reg;
        n_next          = n_reg;
        out_valid_next  = out_valid_reg;
        found_next      = found_reg;
        req_next        = req_reg;
        prod_next       = prod_reg;
        exp_new_next    = exp_new_reg;
        pos_next        = pos_reg;
        target_next     = target_reg;
        free_next       = free_reg;
        kept_tag_next   = kept_tag_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_tag_next    = res_tag_reg;
        out_data_next   = out_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_raddr       = '0;
        mem_wdata       = rdata_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_data;
                    prod_next  = PROD_W'(in_data.delay_seconds) * PROD_W'(tps_reg);
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                exp_new_next = add_sat;
                n_next       = '0;
                res_tag_next = '0;
                case (req_reg.func)
                    stq_pkg::FUNC_TICK:
                    begin
                        clock_next = (clock_reg == TIME_MAX) ? clock_reg : clock_reg + 1'b1;
                        state_next = S_TICK_CHK;
                    end
                    stq_pkg::FUNC_ADD:
                    begin
                        if (req_reg.delay_seconds == '0 || cnt_reg == CW'(QUEUE_DEPTH))
                        begin
                            res_status_next = stq_pkg::ST_REJECTED;
                            res_handle_next = '0;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            free_next  = '0;
                            state_next = S_FREE;
                        end
                    end
                    default:
                    begin
                        if (!h_ok)
                        begin
                            res_status_next = stq_pkg::ST_REJECTED;
                            res_handle_next = req_reg.entry_handle;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            target_next = h_ext[AW-1:0];
                            state_next  = S_FIND_RD;
                        end
                    end
                endcase
            end

            // Lowest free handle, one bit a cycle
            S_FREE:
            begin
                if (!in_use_reg[free_reg])
                begin
                    in_use_next[free_reg] = 1'b1;
                    target_next           = free_reg;
                    kept_tag_next         = req_reg.callback_tag;
                    res_status_next       = stq_pkg::ST_ADDED;
                    res_handle_next       = to_hout(free_reg);
                    state_next            = S_INS_RD;
                end
                else
                    free_next = free_reg + 1'b1;
            end

            S_FIND_RD:
            begin
                mem_raddr  = '0;
                pos_next   = '0;
                found_next = 1'b0;
                state_next = S_FIND;
            end

            // Search by handle; entries after the hit move up one place
            S_FIND:
            begin
                mem_raddr = pos_inc[AW-1:0];
                if (found_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_dec[AW-1:0];
                    mem_wdata = rdata_reg;
                end
                else if (rdata_reg.handle == target_reg)
                begin
                    found_next    = 1'b1;
                    kept_tag_next = rdata_reg.tag;
                end
                if (pos_inc == cnt_reg)
                begin
                    cnt_next = cnt_dec;
                    case (req_reg.func)
                        stq_pkg::FUNC_TICK:
                        begin
                            n_next     = n_reg + 1'b1;
                            state_next = S_EMIT;
                        end
                        stq_pkg::FUNC_REMOVE:
                        begin
                            in_use_next[target_reg] = 1'b0;
                            res_status_next         = stq_pkg::ST_REMOVED;
                            res_handle_next         = req_reg.entry_handle;
                            state_next              = S_EMIT;
                        end
                        default:
                        begin
                            res_status_next = stq_pkg::ST_UPDATED;
                            res_handle_next = req_reg.entry_handle;
                            state_next      = S_INS_RD;
                        end
                    endcase
                end
                else
                    pos_next = pos_inc;
            end

            S_INS_RD:
            begin
                if (cnt_reg == '0)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    mem_wdata  = new_entry;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    mem_raddr  = cnt_dec[AW-1:0];
                    pos_next   = cnt_reg;
                    state_next = S_INS;
                end
            end

            // Walk down from the tail; later expiries move down one place
            S_INS:
            begin
                mem_raddr = pos_m2[AW-1:0];
                mem_we    = 1'b1;
                mem_waddr = pos_reg[AW-1:0];
                if (rdata_reg.expiry > exp_new_reg)
                begin
                    mem_wdata = rdata_reg;
                    pos_next  = pos_dec;
                    if (pos_dec == '0)
                        state_next = S_INS_LAST;
                end
                else
                begin
                    mem_wdata  = new_entry;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_EMIT;
                end
            end

            S_INS_LAST:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = new_entry;
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_EMIT;
            end

            // Pop the head if due and fewer than MAX_RESULTS results were given
            S_TICK_CHK:
            begin
                if (head_due && (n_reg < NW'(stq_pkg::MAX_RESULTS)))
                begin
                    in_use_next[head_reg.handle] = 1'b0;
                    target_next     = head_reg.handle;
                    res_status_next = stq_pkg::ST_EXPIRED;
                    res_handle_next = to_hout(head_reg.handle);
                    res_tag_next    = head_reg.tag;
                    state_next      = S_FIND_RD;
                end
                else
                begin
                    res_status_next = stq_pkg::ST_IDLE_TICK;
                    res_handle_next = '0;
                    res_tag_next    = '0;
                    state_next      = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.status        = res_status_reg;
                    out_data_next.handle_out    = res_handle_reg;
                    out_data_next.tag_out       = res_tag_reg;
                    out_data_next.next_timeout  = nt;
                    out_data_next.queue_empty   = (cnt_reg == '0);
                    out_data_next.last          = emit_last;
                    state_next = emit_last ? S_IDLE : S_TICK_CHK;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // Mirror of store position 0
    always_comb
    begin
        head_next = head_reg;
        if (mem_we && mem_waddr == '0)
            head_next = mem_wdata;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tps_reg       <= stq_pkg::TPS_RESET;
            clock_reg     <= '0;
            cnt_reg       <= '0;
            in_use_reg    <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tps_reg       <= tps_next;
            clock_reg     <= clock_next;
            cnt_reg       <= cnt_next;
            in_use_reg    <= in_use_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
        end
    end

    // Payload state
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        prod_reg       <= prod_next;
        exp_new_reg    <= exp_new_next;
        head_reg       <= head_next;
        pos_reg        <= pos_next;
        target_reg     <= target_next;
        free_reg       <= free_next;
        kept_tag_reg   <= kept_tag_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_tag_reg    <= res_tag_next;
        out_data_reg   <= out_data_next;
    end

    // Entry store: one write, one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            entry_mem[mem_waddr] <= mem_wdata;
        rdata_reg <= entry_mem[mem_raddr];
    end

`ifndef SYNTHESIS
    // Fill count stays within the store
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(QUEUE_DEPTH))
        else $error("pending count beyond queue depth");

    // Handles in use match pending entries between requests
    a_handles_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ($countones(in_use_reg) == int'(cnt_reg)))
        else $error("handle map out of step with pending count");

    // Empty queue reports an infinite timeout
    a_empty_timeout: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.queue_empty) |-> (out_data_reg.next_timeout == '1))
        else $error("empty queue with finite timeout");

    // Only expired results carry a tag
    a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status != stq_pkg::ST_EXPIRED)
            |-> (out_data_reg.tag_out == '0))
        else $error("tag on a result that is not an expiry");

    // A new request is taken only after the last result is loaded
    a_last_before_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && state_next == S_IDLE) |-> emit_last)
        else $error("request ended without last mark");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for the sorted timer queue: directed table plus random requests.

module tb_top;

    import stq_pkg::*;

    localparam int  DEPTH      = 16;
    localparam int  TIME_W     = 48;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam int  SETTLE     = 64;
    localparam int  PHASE_REQS = 30;
    localparam int  LONG_HOLD  = 300;
    localparam stq_out_t NO_REPLY = '0;

    // One directed request; want is used only where typed is set
    typedef struct packed {
        stq_in_t  req;
        logic     typed;
        stq_out_t want;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    stq_in_t             in_data;
    logic                out_valid;
    logic                out_ready;
    stq_out_t            out_data;
    logic                cfg_wr_en;
    logic [TPS_W-1:0]    cfg_wr_data;

    // Replies still owed by the block, oldest first
    stq_out_t            awaited_replies[$];
    int                  fail_count;
    int                  rx_hold;

    // Shadow copy of the timer queue
    logic [TIME_W-1:0]   shadow_clock;
    logic [TIME_W-1:0]   shadow_expiry [DEPTH];
    logic [TAG_W-1:0]    shadow_tag [DEPTH];
    logic [HANDLE_W-1:0] shadow_slot [DEPTH];
    int                  shadow_count;
    bit                  shadow_used [DEPTH];
    logic [TPS_W-1:0]    shadow_tps;

    // Directed table: reset values, extremes, rejects, equal expiry, zero-delay re-arm
    dir_row_t directed_rows [15] = '{
        {FUNC_TICK,   16'd0,     32'h0000_0000, 4'd0,  1'b1,
         ST_IDLE_TICK, 4'd0,  32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1},
        {FUNC_ADD,    16'd0,     32'h1234_5678, 4'd0,  1'b1,
         ST_REJECTED,  4'd0,  32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1},
        {FUNC_REMOVE, 16'd0,     32'h0000_0000, 4'd15, 1'b1,
         ST_REJECTED,  4'd15, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1},
        {FUNC_UPDATE, 16'd5,     32'h0000_0000, 4'd0,  1'b1,
         ST_REJECTED,  4'd0,  32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1},
        {FUNC_ADD,    16'd1,     32'hFFFF_FFFF, 4'd15, 1'b1,
         ST_ADDED,     4'd0,  32'd0, 32'd1000,      1'b0, 1'b1},
        {FUNC_ADD,    16'hFFFF,  32'h0000_0000, 4'd0,  1'b1,
         ST_ADDED,     4'd1,  32'd0, 32'd1000,      1'b0, 1'b1},
        {FUNC_ADD,    16'd1,     32'hA5A5_A5A5, 4'd0,  1'b1,
         ST_ADDED,     4'd2,  32'd0, 32'd1000,      1'b0, 1'b1},
        {FUNC_TICK,   16'd0,     32'h0000_0000, 4'd0,  1'b1,
         ST_IDLE_TICK, 4'd0,  32'd0, 32'd999,       1'b0, 1'b1},
        {FUNC_UPDATE, 16'd0,     32'h0000_0000, 4'd0,  1'b1,
         ST_UPDATED,   4'd0,  32'd0, 32'd0,         1'b0, 1'b1},
        {FUNC_TICK,   16'd0,     32'h0000_0000, 4'd0,  1'b0, NO_REPLY},
        {FUNC_REMOVE, 16'd0,     32'h0000_0000, 4'd1,  1'b0, NO_REPLY},
        {FUNC_REMOVE, 16'd0,     32'h0000_0000, 4'd1,  1'b0, NO_REPLY},
        {FUNC_UPDATE, 16'hFFFF,  32'h5A5A_5A5A, 4'd2,  1'b0, NO_REPLY},
        {FUNC_ADD,    16'hFFFF,  32'h0F0F_0F0F, 4'd10, 1'b0, NO_REPLY},
        {FUNC_TICK,   16'hFFFF,  32'hFFFF_FFFF, 4'd15, 1'b0, NO_REPLY}
    };

    // Settings walked after the directed part; zero and all ones included
    logic [TPS_W-1:0] phase_tps [6] = '{20'd1, 20'd0, 20'd1000000, 20'hFFFFF, 20'd2, 20'd1};

    sorted_timer_queue_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length: mostly none, some short, a few long
    function automatic int idle_span();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Time addition that sticks at the top instead of wrapping
    function automatic logic [TIME_W-1:0] time_sat_add(logic [TIME_W-1:0] a, logic [63:0] b);
        logic [64:0] sum;
        sum = {17'd0, a} + {1'b0, b};
        if (sum > {17'd0, TIME_MAX})
            return TIME_MAX;
        return sum[TIME_W-1:0];
    endfunction

    // Reply with the queue summary as it stands now
    function automatic stq_out_t timer_reply(logic [STATUS_W-1:0] status,
                                             logic [HANDLE_W-1:0] handle,
                                             logic [TAG_W-1:0] tag, logic last);
        stq_out_t         rep;
        logic [TIME_W-1:0] diff;
        rep.status       = status;
        rep.handle_out   = handle;
        rep.tag_out      = tag;
        rep.last         = last;
        rep.queue_empty  = (shadow_count == 0);
        rep.next_timeout = '1;
        if (shadow_count > 0)
        begin
            if (shadow_expiry[0] <= shadow_clock)
                rep.next_timeout = '0;
            else
            begin
                diff = shadow_expiry[0] - shadow_clock;
                rep.next_timeout = (diff > 48'hFFFF_FFFF) ? '1 : diff[31:0];
            end
        end
        return rep;
    endfunction

    function automatic void drop_entry(int pos);
        for (int i = pos; i + 1 < shadow_count; i++)
        begin
            shadow_expiry[i] = shadow_expiry[i+1];
            shadow_tag[i]    = shadow_tag[i+1];
            shadow_slot[i]   = shadow_slot[i+1];
        end
        shadow_count--;
    endfunction

    // Insert behind every entry with the same or earlier expiry
    function automatic void place_entry(logic [TIME_W-1:0] expiry, logic [TAG_W-1:0] tag,
                                        logic [HANDLE_W-1:0] handle);
        int pos;
        pos = 0;
        while (pos < shadow_count && shadow_expiry[pos] <= expiry)
            pos++;
        for (int i = shadow_count; i > pos; i--)
        begin
            shadow_expiry[i] = shadow_expiry[i-1];
            shadow_tag[i]    = shadow_tag[i-1];
            shadow_slot[i]   = shadow_slot[i-1];
        end
        shadow_expiry[pos] = expiry;
        shadow_tag[pos]    = tag;
        shadow_slot[pos]   = handle;
        shadow_count++;
    endfunction

    // Apply one request to the shadow queue and return the replies it causes
    task automatic timer_apply(input stq_in_t r, output stq_out_t replies[$]);
        logic [63:0]         ticks;
        logic [HANDLE_W-1:0] eh;
        logic [TAG_W-1:0]    kept;
        int                  pos;
        int                  slot;
        replies = {};
        ticks = 64'(r.delay_seconds) * 64'(shadow_tps);
        case (r.func)
            FUNC_TICK:
            begin
                shadow_clock = time_sat_add(shadow_clock, 64'd1);
                while (shadow_count > 0 && replies.size() < MAX_RESULTS
                       && shadow_expiry[0] <= shadow_clock)
                begin
                    eh   = shadow_slot[0];
                    kept = shadow_tag[0];
                    shadow_used[eh] = 1'b0;
                    drop_entry(0);
                    replies.push_back(timer_reply(ST_EXPIRED, eh, kept, 1'b0));
                end
                if (replies.size() == 0)
                    replies.push_back(timer_reply(ST_IDLE_TICK, '0, '0, 1'b1));
                else
                    replies[replies.size()-1].last = 1'b1;
            end
            FUNC_ADD:
            begin
                slot = -1;
                for (int i = DEPTH - 1; i >= 0; i--)
                    if (!shadow_used[i])
                        slot = i;
                if (r.delay_seconds == 0 || shadow_count >= DEPTH || slot < 0)
                    replies.push_back(timer_reply(ST_REJECTED, '0, '0, 1'b1));
                else
                begin
                    shadow_used[slot] = 1'b1;
                    place_entry(time_sat_add(shadow_clock, ticks), r.callback_tag,
                                HANDLE_W'(slot));
                    replies.push_back(timer_reply(ST_ADDED, HANDLE_W'(slot), '0, 1'b1));
                end
            end
            default:
            begin
                pos = -1;
                if (shadow_used[r.entry_handle])
                    for (int i = 0; i < shadow_count; i++)
                        if (pos < 0 && shadow_slot[i] == r.entry_handle)
                            pos = i;
                if (pos < 0)
                    replies.push_back(timer_reply(ST_REJECTED, r.entry_handle, '0, 1'b1));
                else if (r.func == FUNC_REMOVE)
                begin
                    shadow_used[r.entry_handle] = 1'b0;
                    drop_entry(pos);
                    replies.push_back(timer_reply(ST_REMOVED, r.entry_handle, '0, 1'b1));
                end
                else
                begin
                    kept = shadow_tag[pos];
                    drop_entry(pos);
                    place_entry(time_sat_add(shadow_clock, ticks), kept, r.entry_handle);
                    replies.push_back(timer_reply(ST_UPDATED, r.entry_handle, '0, 1'b1));
                end
            end
        endcase
    endtask

    // Offer one request, book its replies, wait for acceptance, then maybe idle
    task automatic send_request(input stq_in_t r, input logic typed, input stq_out_t want);
        stq_out_t replies[$];
        int       gap;
        in_data  <= r;
        in_valid <= 1'b1;
        timer_apply(r, replies);
        if (typed)
            awaited_replies.push_back(want);
        else
            foreach (replies[i])
                awaited_replies.push_back(replies[i]);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        gap = idle_span();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off new requests until every owed reply is in and the block has settled
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_tps(input logic [TPS_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        shadow_tps   = value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Random request, biased toward live handles and short delays
    function automatic stq_in_t random_request();
        stq_in_t             r;
        int                  pick;
        logic [HANDLE_W-1:0] live[$];
        r.callback_tag  = $urandom();
        r.entry_handle  = HANDLE_W'($urandom_range(0, DEPTH - 1));
        pick = $urandom_range(0, 99);
        if (pick < 5)
            r.delay_seconds = '0;
        else if (pick < 80)
            r.delay_seconds = DELAY_W'($urandom_range(1, 6));
        else if (pick < 95)
            r.delay_seconds = DELAY_W'($urandom_range(7, 40));
        else
            r.delay_seconds = DELAY_W'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 40)
            r.func = FUNC_TICK;
        else if (pick < 70)
            r.func = FUNC_ADD;
        else if (pick < 85)
            r.func = FUNC_REMOVE;
        else
            r.func = FUNC_UPDATE;
        if (r.func == FUNC_REMOVE || r.func == FUNC_UPDATE)
        begin
            for (int h = 0; h < DEPTH; h++)
                if (shadow_used[h])
                    live.push_back(HANDLE_W'(h));
            if (live.size() > 0 && $urandom_range(0, 9) < 8)
                r.entry_handle = live[$urandom_range(0, live.size() - 1)];
        end
        return r;
    endfunction

    // Field-by-field comparison
    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Reply checker
    always @(posedge clk)
    begin
        stq_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_replies.size() == 0)
            begin
                $error("reply with none owed: status %0d handle %0d",
                       out_data.status, out_data.handle_out);
                fail_count++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                check_field("status", 64'(want.status), 64'(out_data.status));
                check_field("handle_out", 64'(want.handle_out), 64'(out_data.handle_out));
                check_field("tag_out", 64'(want.tag_out), 64'(out_data.tag_out));
                check_field("next_timeout", 64'(want.next_timeout),
                            64'(out_data.next_timeout));
                check_field("queue_empty", 64'(want.queue_empty), 64'(out_data.queue_empty));
                check_field("last", 64'(want.last), 64'(out_data.last));
            end
        end
    end

    // Receiver: random stalls, calm stretches, and a long hold on request
    initial
    begin
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        out_ready  = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                stall_left = rx_hold;
                rx_hold    = 0;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (run_left > 0)
                    run_left--;
                else if ($urandom_range(0, 9) == 0)
                    run_left = 80;
                else
                begin
                    run_left   = $urandom_range(0, 12);
                    stall_left = idle_span();
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        stq_in_t r;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        fail_count   = 0;
        rx_hold      = 0;
        shadow_clock = '0;
        shadow_count = 0;
        shadow_tps   = TPS_RESET;
        foreach (shadow_used[i])
            shadow_used[i] = 1'b0;

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed part at the reset rate
        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        foreach (phase_tps[p])
        begin
            wait_quiet();
            write_tps(phase_tps[p]);

            // Zero rate: fill the queue behind a stalled receiver, then expire it all at once
            if (phase_tps[p] == 0)
            begin
                for (int h = 0; h < DEPTH; h++)
                    if (shadow_used[h])
                    begin
                        r = random_request();
                        r.func = FUNC_REMOVE;
                        r.entry_handle = HANDLE_W'(h);
                        send_request(r, 1'b0, NO_REPLY);
                    end
                rx_hold = LONG_HOLD;
                for (int k = 0; k <= DEPTH; k++)
                begin
                    r = random_request();
                    r.func = FUNC_ADD;
                    r.delay_seconds = DELAY_W'($urandom_range(1, 65535));
                    send_request(r, 1'b0, NO_REPLY);
                end
                r = random_request();
                r.func = FUNC_TICK;
                send_request(r, 1'b0, NO_REPLY);
                send_request(r, 1'b0, NO_REPLY);
            end

            for (int k = 0; k < PHASE_REQS; k++)
            begin
                if (k == PHASE_REQS / 2)
                    wait_quiet();
                send_request(random_request(), 1'b0, NO_REPLY);
            end
        end

        wait_quiet();
        if (fail_count == 0)
            $display("sorted_timer_queue_unit: match");
        else
            $display("sorted_timer_queue_unit: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10000000;
        $display("sorted_timer_queue_unit: mismatch");
        $finish;
    end

endmodule

/* files.f */
design/stq_pkg.sv
design/sorted_timer_queue_unit.sv
tb/sv/tb_top.sv
